### design/fdwe_pkg.sv
// ============================================================================
// Fractional divider word encoder package
// Shared widths, command codes, register indexes, sequencer states and
// arithmetic step counts for the fractional divider word encoder.
// ============================================================================
package fdwe_pkg;

    // Item field widths
    localparam int CMD_W  = 3;
    localparam int FREQ_W = 40;
    localparam int INT_W  = 12;
    localparam int FRAC_W = 20;
    localparam int BYTE_W = 8;

    // Configuration register widths
    localparam int XTAL_W = 27;
    localparam int VCO_W  = 30;
    localparam int PLL_W  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FB_FREQ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OUT_FREQ = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FB_ABC   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OUT_ABC  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMBINED = 3'd4;

    // Register index, taken from the word address bit
    localparam logic REG_XTAL = 1'b0;
    localparam logic REG_VCO  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [XTAL_W-1:0] XTAL_RESET = 27'd25000000;
    localparam logic [VCO_W-1:0]  VCO_RESET  = 30'd689929800;

    // Fixed fraction denominator of the frequency commands
    localparam logic [FRAC_W-1:0] FRAC_DENOM = 20'd1048575;

    // Scale of the output frequency argument
    localparam int              MULT_K_W = 10;
    localparam logic [MULT_K_W-1:0] MULT_K = 10'd1000;

    // Register base addresses of the two dividers
    localparam logic [BYTE_W-1:0] BASE_FEEDBACK = 8'd26;
    localparam logic [BYTE_W-1:0] BASE_OUTPUT   = 8'd50;

    // P1 offset
    localparam logic [17:0] P1_OFFSET = 18'd512;

    // Step counts of the shared shift-add/subtract unit
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] CNT_MUL_N = 6'd10;
    localparam logic [CNT_W-1:0] CNT_DIV_A = 6'd42;
    localparam logic [CNT_W-1:0] CNT_MUL_R = 6'd20;
    localparam logic [CNT_W-1:0] CNT_DIV_B = 6'd60;
    localparam logic [CNT_W-1:0] CNT_DIV_Q = 6'd27;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_N,
        S_DIV_A,
        S_MUL_R,
        S_DIV_B,
        S_DIV_Q,
        S_EMIT,
        S_ERR
    } state_t;

endpackage

### design/fdwe_channels.sv
// ============================================================================
// Fractional divider word encoder channels
// Valid/ready channels for command items and register write items.
// ============================================================================

// Command item channel
interface fdwe_in_if;
    logic                        valid;
    logic                        ready;
    logic [fdwe_pkg::CMD_W-1:0]  cmd;
    logic [fdwe_pkg::FREQ_W-1:0] freq_value;
    logic [fdwe_pkg::INT_W-1:0]  int_part;
    logic [fdwe_pkg::FRAC_W-1:0] frac_num;
    logic [fdwe_pkg::FRAC_W-1:0] frac_den;

    modport source (output valid, cmd, freq_value, int_part, frac_num, frac_den,
                    input ready);
    modport sink (input valid, cmd, freq_value, int_part, frac_num, frac_den,
                  output ready);
endinterface

// Register write item channel
interface fdwe_out_if;
    logic                        valid;
    logic                        ready;
    logic [fdwe_pkg::BYTE_W-1:0] reg_addr;
    logic [fdwe_pkg::BYTE_W-1:0] reg_byte;
    logic                        last_write;
    logic                        div_error;

    modport source (output valid, reg_addr, reg_byte, last_write, div_error,
                    input ready);
    modport sink (input valid, reg_addr, reg_byte, last_write, div_error,
                  output ready);
endinterface

### design/fractional_divider_word_encoder_unit.sv
// ============================================================================
// Fractional divider word encoder unit
// Turns divider commands into P1/P2/P3 words and emits them as eight
// register byte writes per divider, using one shared shift-add/subtract unit.
// ============================================================================
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ------------------------------------
//  in_ch     in         valid/ready         cmd, freq_value, int_part,
//                                           frac_num, frac_den
//  out_ch    out        valid/ready         reg_addr, reg_byte, last_write,
//                                           div_error
//  APB       in         psel/penable/pwrite crystal_freq_hz (0x0), vco_target_hz (0x4)
//
//  A feedback-from-frequency command runs a 42-step divide, a 20-step
//  multiply, a 60-step divide and a 27-step divide in the shared unit; an
//  output-from-frequency command adds a 10-step multiply before them, an abc
//  command runs the 27-step divide alone, the combined command both sequences;
//  each divider then hands out its eight items, so the combined command emits
//  twice. An error command hands out a single error item; an unused command
//  is dropped. in_ch.ready is high only in idle. A stalled out_ch holds the
//  sequencer in its emit step. Reset is asynchronous and needs no clearing pass.
//
module fractional_divider_word_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    fdwe_in_if.sink     in_ch,
    fdwe_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    fdwe_pkg::state_t state_reg, state_next;

    logic [fdwe_pkg::XTAL_W-1:0] xtal_reg, xtal_next;
    logic [fdwe_pkg::VCO_W-1:0]  vco_reg, vco_next;
    logic [fdwe_pkg::PLL_W-1:0]  pll_reg, pll_next;

    logic        cont_reg, cont_next;
    logic        path_reg, path_next;
    logic        out_valid_reg, out_valid_next;

    logic [63:0]                  acc_reg, acc_next;
    logic [63:0]                  num_reg, num_next;
    logic [39:0]                  opd_reg, opd_next;
    logic [39:0]                  dvs_reg, dvs_next;
    logic [fdwe_pkg::FREQ_W-1:0]  frq_reg, frq_next;
    logic [fdwe_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [10:0]                  a_reg, a_next;
    logic [fdwe_pkg::FRAC_W-1:0]  c_reg, c_next;
    logic [17:0]                  p1_reg, p1_next;
    logic [19:0]                  p2_reg, p2_next;
    logic [2:0]                   idx_reg, idx_next;

    logic [fdwe_pkg::BYTE_W-1:0]  out_addr_reg, out_addr_next;
    logic [fdwe_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_err_reg, out_err_next;

    logic        in_fire;
    logic        cfg_write;
    logic        slot_free;
    logic        is_mul;
    logic        busy_arith;
    logic        step_done;
    logic        cmd_err;
    logic        cmd_known;

    logic [63:0] au_t;
    logic [63:0] au_opb;
    logic [63:0] au_opb_eff;
    logic [64:0] au_sum;
    logic [63:0] acc_it;
    logic [63:0] num_it;

    logic [fdwe_pkg::BYTE_W-1:0] emit_base;
    logic [fdwe_pkg::BYTE_W-1:0] emit_byte;

    // ------------------------------------------------------------------------
    // Handshakes and configuration port
    // ------------------------------------------------------------------------
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign pready    = 1'b1;

    assign in_ch.ready       = (state_reg == fdwe_pkg::S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.reg_addr   = out_addr_reg;
    assign out_ch.reg_byte   = out_byte_reg;
    assign out_ch.last_write = out_last_reg;
    assign out_ch.div_error  = out_err_reg;

    // Register read mux
    always_comb
    begin
        case (paddr[2])
            fdwe_pkg::REG_XTAL: prdata = {5'b0, xtal_reg};
            fdwe_pkg::REG_VCO:  prdata = {2'b0, vco_reg};
            default:            prdata = '0;
        endcase
    end

    // Register writes
    always_comb
    begin
        xtal_next = xtal_reg;
        vco_next  = vco_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                fdwe_pkg::REG_XTAL: xtal_next = pwdata[fdwe_pkg::XTAL_W-1:0];
                fdwe_pkg::REG_VCO:  vco_next  = pwdata[fdwe_pkg::VCO_W-1:0];
                default:            xtal_next = xtal_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Command decode: divisor check and known commands
    // ------------------------------------------------------------------------
    always_comb
    begin
        cmd_known = 1'b1;
        cmd_err   = 1'b0;
        case (in_ch.cmd)
            fdwe_pkg::CMD_FB_FREQ:  cmd_err = (xtal_reg == '0);
            fdwe_pkg::CMD_OUT_FREQ: cmd_err = (in_ch.freq_value == '0);
            fdwe_pkg::CMD_FB_ABC:   cmd_err = (in_ch.frac_den == '0);
            fdwe_pkg::CMD_OUT_ABC:  cmd_err = (in_ch.frac_den == '0);
            fdwe_pkg::CMD_COMBINED:
                cmd_err = (xtal_reg == '0) || (in_ch.freq_value == '0);
            default:                cmd_known = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Shared unit: one step of restoring division or MSB-first shift-add
    // multiply. The operand bit streams out of the top of num_reg.
    // ------------------------------------------------------------------------
    assign is_mul     = (state_reg == fdwe_pkg::S_MUL_N) ||
                        (state_reg == fdwe_pkg::S_MUL_R);
    assign busy_arith = is_mul ||
                        (state_reg == fdwe_pkg::S_DIV_A) ||
                        (state_reg == fdwe_pkg::S_DIV_B) ||
                        (state_reg == fdwe_pkg::S_DIV_Q);
    assign step_done  = (cnt_reg == fdwe_pkg::CNT_W'(1));

    assign au_t       = {acc_reg[62:0], is_mul ? 1'b0 : num_reg[63]};
    assign au_opb     = {24'b0, opd_reg};
    assign au_opb_eff = is_mul ? (num_reg[63] ? au_opb : 64'b0) : ~au_opb;
    assign au_sum     = {1'b0, au_t} + {1'b0, au_opb_eff} + {64'b0, !is_mul};

    always_comb
    begin
        if (is_mul)
        begin
            acc_it = au_sum[63:0];
            num_it = {num_reg[62:0], 1'b0};
        end
        else
        begin
            // Carry out set means no borrow: the partial remainder fits
            acc_it = au_sum[64] ? au_sum[63:0] : au_t;
            num_it = {num_reg[62:0], au_sum[64]};
        end
    end

    // ------------------------------------------------------------------------
    // Byte layout of the current item
    // ------------------------------------------------------------------------
    assign emit_base = path_reg ? fdwe_pkg::BASE_OUTPUT : fdwe_pkg::BASE_FEEDBACK;

    always_comb
    begin
        case (idx_reg)
            3'd0:    emit_byte = c_reg[15:8];
            3'd1:    emit_byte = c_reg[7:0];
            3'd2:    emit_byte = {6'b0, p1_reg[17:16]};
            3'd3:    emit_byte = p1_reg[15:8];
            3'd4:    emit_byte = p1_reg[7:0];
            3'd5:    emit_byte = {c_reg[19:16], p2_reg[19:16]};
            3'd6:    emit_byte = p2_reg[15:8];
            3'd7:    emit_byte = p2_reg[7:0];
            default: emit_byte = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdwe_pkg::S_IDLE:
            begin
                if (in_fire && cmd_known)
                begin
                    if (cmd_err)
                        state_next = fdwe_pkg::S_ERR;
                    else
                    begin
                        case (in_ch.cmd)
                            fdwe_pkg::CMD_OUT_FREQ: state_next = fdwe_pkg::S_MUL_N;
                            fdwe_pkg::CMD_FB_ABC:   state_next = fdwe_pkg::S_DIV_Q;
                            fdwe_pkg::CMD_OUT_ABC:  state_next = fdwe_pkg::S_DIV_Q;
                            default:                state_next = fdwe_pkg::S_DIV_A;
                        endcase
                    end
                end
            end
            fdwe_pkg::S_MUL_N:
                if (step_done) state_next = fdwe_pkg::S_DIV_A;
            fdwe_pkg::S_DIV_A:
                if (step_done) state_next = fdwe_pkg::S_MUL_R;
            fdwe_pkg::S_MUL_R:
                if (step_done) state_next = fdwe_pkg::S_DIV_B;
            fdwe_pkg::S_DIV_B:
                if (step_done) state_next = fdwe_pkg::S_DIV_Q;
            fdwe_pkg::S_DIV_Q:
                if (step_done) state_next = fdwe_pkg::S_EMIT;
            fdwe_pkg::S_EMIT:
            begin
                if (slot_free && idx_reg == 3'd7)
                    state_next = cont_reg ? fdwe_pkg::S_MUL_N : fdwe_pkg::S_IDLE;
            end
            fdwe_pkg::S_ERR:
                if (slot_free) state_next = fdwe_pkg::S_IDLE;
            default:
                state_next = fdwe_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer outputs: datapath loads, steps and item hand-out
    // ------------------------------------------------------------------------
    always_comb
    begin
        acc_next       = acc_reg;
        num_next       = num_reg;
        opd_next       = opd_reg;
        dvs_next       = dvs_reg;
        frq_next       = frq_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        c_next         = c_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        idx_next       = idx_reg;
        pll_next       = pll_reg;
        cont_next      = cont_reg;
        path_next      = path_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_addr_next  = out_addr_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        // Arithmetic steps advance by default
        if (busy_arith)
        begin
            acc_next = acc_it;
            num_next = num_it;
            cnt_next = cnt_reg - fdwe_pkg::CNT_W'(1);
        end

        case (state_reg)
            fdwe_pkg::S_IDLE:
            begin
                if (in_fire && cmd_known && !cmd_err)
                begin
                    frq_next = in_ch.freq_value;
                    acc_next = '0;
                    case (in_ch.cmd)
                        fdwe_pkg::CMD_FB_FREQ:
                        begin
                            // Feedback divider: f / crystal
                            dvs_next  = {13'b0, xtal_reg};
                            opd_next  = {13'b0, xtal_reg};
                            num_next  = {2'b0, in_ch.freq_value, 22'b0};
                            cnt_next  = fdwe_pkg::CNT_DIV_A;
                            path_next = 1'b0;
                            cont_next = 1'b0;
                            pll_next  = in_ch.freq_value[fdwe_pkg::PLL_W-1:0];
                        end
                        fdwe_pkg::CMD_COMBINED:
                        begin
                            // Feedback from the VCO target, output follows
                            dvs_next  = {13'b0, xtal_reg};
                            opd_next  = {13'b0, xtal_reg};
                            num_next  = {12'b0, vco_reg, 22'b0};
                            cnt_next  = fdwe_pkg::CNT_DIV_A;
                            path_next = 1'b0;
                            cont_next = 1'b1;
                            pll_next  = {2'b0, vco_reg};
                        end
                        fdwe_pkg::CMD_OUT_FREQ:
                        begin
                            // Output divider: first pll * 1000
                            dvs_next  = in_ch.freq_value;
                            opd_next  = {8'b0, pll_reg};
                            num_next  = {fdwe_pkg::MULT_K, 54'b0};
                            cnt_next  = fdwe_pkg::CNT_MUL_N;
                            path_next = 1'b1;
                            cont_next = 1'b0;
                        end
                        default:
                        begin
                            // Direct a, b, c: only 128*b / c is left to do
                            a_next    = in_ch.int_part[10:0];
                            c_next    = in_ch.frac_den;
                            opd_next  = {20'b0, in_ch.frac_den};
                            num_next  = {in_ch.frac_num, 7'b0, 37'b0};
                            cnt_next  = fdwe_pkg::CNT_DIV_Q;
                            path_next = (in_ch.cmd == fdwe_pkg::CMD_OUT_ABC);
                            cont_next = 1'b0;
                        end
                    endcase
                end
            end
            fdwe_pkg::S_MUL_N:
            begin
                if (step_done)
                begin
                    acc_next = '0;
                    num_next = {acc_it[41:0], 22'b0};
                    opd_next = dvs_reg;
                    cnt_next = fdwe_pkg::CNT_DIV_A;
                end
            end
            fdwe_pkg::S_DIV_A:
            begin
                if (step_done)
                begin
                    // Integer part; remainder times the denominator comes next
                    a_next   = num_it[10:0];
                    acc_next = '0;
                    opd_next = acc_it[39:0];
                    num_next = {fdwe_pkg::FRAC_DENOM, 44'b0};
                    cnt_next = fdwe_pkg::CNT_MUL_R;
                end
            end
            fdwe_pkg::S_MUL_R:
            begin
                if (step_done)
                begin
                    acc_next = '0;
                    num_next = {acc_it[59:0], 4'b0};
                    opd_next = dvs_reg;
                    cnt_next = fdwe_pkg::CNT_DIV_B;
                end
            end
            fdwe_pkg::S_DIV_B:
            begin
                if (step_done)
                begin
                    // Numerator b is the quotient; divide 128*b by the denominator
                    c_next   = fdwe_pkg::FRAC_DENOM;
                    acc_next = '0;
                    opd_next = {20'b0, fdwe_pkg::FRAC_DENOM};
                    num_next = {num_it[19:0], 7'b0, 37'b0};
                    cnt_next = fdwe_pkg::CNT_DIV_Q;
                end
            end
            fdwe_pkg::S_DIV_Q:
            begin
                if (step_done)
                begin
                    p1_next  = {a_reg, 7'b0} + num_it[17:0] - fdwe_pkg::P1_OFFSET;
                    p2_next  = acc_it[19:0];
                    idx_next = 3'd0;
                end
            end
            fdwe_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = emit_base + {5'b0, idx_reg};
                    out_byte_next  = emit_byte;
                    out_last_next  = (idx_reg == 3'd7) && !cont_reg;
                    out_err_next   = 1'b0;
                    idx_next       = idx_reg + 3'd1;
                    if (idx_reg == 3'd7 && cont_reg)
                    begin
                        // Combined command goes on with the output divider
                        cont_next = 1'b0;
                        path_next = 1'b1;
                        dvs_next  = frq_reg;
                        opd_next  = {8'b0, pll_reg};
                        acc_next  = '0;
                        num_next  = {fdwe_pkg::MULT_K, 54'b0};
                        cnt_next  = fdwe_pkg::CNT_MUL_N;
                    end
                end
            end
            fdwe_pkg::S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdwe_pkg::S_IDLE;
            xtal_reg      <= fdwe_pkg::XTAL_RESET;
            vco_reg       <= fdwe_pkg::VCO_RESET;
            pll_reg       <= '0;
            cont_reg      <= 1'b0;
            path_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            xtal_reg      <= xtal_next;
            vco_reg       <= vco_next;
            pll_reg       <= pll_next;
            cont_reg      <= cont_next;
            path_reg      <= path_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Datapath and payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        num_reg      <= num_next;
        opd_reg      <= opd_next;
        dvs_reg      <= dvs_next;
        frq_reg      <= frq_next;
        cnt_reg      <= cnt_next;
        a_reg        <= a_next;
        c_reg        <= c_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        idx_reg      <= idx_next;
        out_addr_reg <= out_addr_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The shared unit never runs with an exhausted step count.
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_arith |-> cnt_reg != '0)
        else $error("shared unit stepping with zero count");

    // An error item always closes its command.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_last_reg)
        else $error("error item without last flag");

    // A known command always leaves idle.
    a_cmd_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cmd_known |=> state_reg != fdwe_pkg::S_IDLE)
        else $error("known command did not start");

    // The final byte of a command ends with a pending last item and idle.
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fdwe_pkg::S_EMIT && slot_free && idx_reg == 3'd7 && !cont_reg
        |=> state_reg == fdwe_pkg::S_IDLE && out_valid_reg && out_last_reg)
        else $error("final byte not handed out as last item");

endmodule

### tb/tb_fractional_divider_word_encoder_unit.sv
// ----------------------------------------------------------------------------
// Fractional divider word encoder unit testbench
// Drives divider commands into the unit and checks every register byte write
// it emits against an in-bench predictor of the P1/P2/P3 encoding. A short
// directed table comes first, followed by random commands under several
// crystal and VCO register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fractional_divider_word_encoder_unit;

    // Command codes the unit ignores
    localparam logic [fdwe_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [fdwe_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [fdwe_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 350;
    localparam int IDLE_PCT      = 11;
    localparam int NUM_DIRECTED  = 24;
    localparam int NUM_PHASES    = 6;

    localparam logic [fdwe_pkg::FREQ_W-1:0] FREQ_MAX = {fdwe_pkg::FREQ_W{1'b1}};
    localparam logic [fdwe_pkg::INT_W-1:0]  INT_MAX  = {fdwe_pkg::INT_W{1'b1}};
    localparam logic [fdwe_pkg::FRAC_W-1:0] FRAC_MAX = {fdwe_pkg::FRAC_W{1'b1}};

    typedef struct packed {
        logic [fdwe_pkg::CMD_W-1:0]  cmd;
        logic [fdwe_pkg::FREQ_W-1:0] freq_value;
        logic [fdwe_pkg::INT_W-1:0]  int_part;
        logic [fdwe_pkg::FRAC_W-1:0] frac_num;
        logic [fdwe_pkg::FRAC_W-1:0] frac_den;
    } divider_cmd_t;

    typedef struct packed {
        divider_cmd_t item;
        logic         typed_error;
    } stim_row_t;

    typedef struct packed {
        logic [fdwe_pkg::BYTE_W-1:0] reg_addr;
        logic [fdwe_pkg::BYTE_W-1:0] reg_byte;
        logic                        last_write;
        logic                        div_error;
    } reg_write_t;

    typedef struct {
        logic [fdwe_pkg::XTAL_W-1:0] xtal;
        logic [fdwe_pkg::VCO_W-1:0]  vco;
        bit                          calm;
        int                          count;
    } phase_t;

    localparam reg_write_t ERROR_WRITE = '{8'd0, 8'd0, 1'b1, 1'b1};

    // Directed table; typed_error rows expect the single error item
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{fdwe_pkg::CMD_OUT_FREQ, 40'd1000, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_FREQ, 40'd0, INT_MAX, FRAC_MAX, FRAC_MAX}, 1'b1},
        '{'{fdwe_pkg::CMD_FB_FREQ, 40'd689929800, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_FREQ, 40'd14097000000, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_FB_FREQ, 40'd0, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_FB_FREQ, FREQ_MAX, INT_MAX, FRAC_MAX, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_FREQ, 40'd1, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_FREQ, FREQ_MAX, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_FB_ABC, FREQ_MAX, 12'd0, 20'd0, 20'd1}, 1'b0},
        '{'{fdwe_pkg::CMD_FB_ABC, 40'd0, INT_MAX, FRAC_MAX, FRAC_MAX}, 1'b0},
        '{'{fdwe_pkg::CMD_FB_ABC, FREQ_MAX, INT_MAX, FRAC_MAX, 20'd0}, 1'b1},
        '{'{fdwe_pkg::CMD_OUT_ABC, 40'd0, INT_MAX, 20'd0, 20'd1}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_ABC, 40'd0, 12'd0, FRAC_MAX, 20'd1}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_ABC, 40'd5, 12'd1, 20'd1, 20'd0}, 1'b1},
        '{'{fdwe_pkg::CMD_OUT_ABC, 40'd0, 12'd36, 20'd1, FRAC_MAX}, 1'b0},
        '{'{fdwe_pkg::CMD_COMBINED, 40'd0, INT_MAX, FRAC_MAX, FRAC_MAX}, 1'b1},
        '{'{fdwe_pkg::CMD_COMBINED, 40'd1, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_COMBINED, FREQ_MAX, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_COMBINED, 40'd14097000000, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{CMD_RSVD_5, 40'd14097000000, INT_MAX, FRAC_MAX, 20'd0}, 1'b0},
        '{'{CMD_RSVD_6, FREQ_MAX, 12'd7, 20'd3, 20'd9}, 1'b0},
        '{'{CMD_RSVD_7, 40'd0, 12'd0, 20'd0, 20'd0}, 1'b0},
        '{'{fdwe_pkg::CMD_FB_ABC, 40'd0, 12'd4, 20'd0, 20'd1}, 1'b0},
        '{'{fdwe_pkg::CMD_OUT_FREQ, 40'd7000000000, 12'd0, 20'd0, 20'd0}, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fdwe_in_if  in_ch ();
    fdwe_out_if out_ch ();

    fractional_divider_word_encoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the configuration and the stored feedback frequency
    logic [fdwe_pkg::XTAL_W-1:0] xtal_hz;
    logic [fdwe_pkg::VCO_W-1:0]  vco_hz;
    logic [fdwe_pkg::PLL_W-1:0]  pll_hz;

    reg_write_t pending_writes [$];
    int         mismatch_count;
    int         cycle_count;
    bit         calm;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fractional_divider_word_encoder_unit test failed");
            $finish;
        end
    end

    // Print one line for a mismatch and count it.
    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    // Push the eight byte writes of one divider for ratio a + b/c.
    function automatic void encode_divider(input logic [fdwe_pkg::BYTE_W-1:0] base,
                                           input bit [63:0] a,
                                           input bit [63:0] b,
                                           input bit [63:0] c,
                                           input bit fin);
        bit [63:0] q;
        bit [17:0] p1;
        bit [19:0] p2;
        bit [19:0] p3;
        bit [63:0] t1;
        bit [63:0] t2;
        q  = (64'd128 * b) / c;
        t1 = 64'd128 * a + q - 64'(fdwe_pkg::P1_OFFSET);
        t2 = 64'd128 * b - c * q;
        p1 = t1[17:0];
        p2 = t2[19:0];
        p3 = c[19:0];
        pending_writes.push_back(reg_write_t'{base + 8'd0, p3[15:8], 1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd1, p3[7:0], 1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd2, {6'd0, p1[17:16]}, 1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd3, p1[15:8], 1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd4, p1[7:0], 1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd5, {p3[19:16], p2[19:16]},
                                              1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd6, p2[15:8], 1'b0, 1'b0});
        pending_writes.push_back(reg_write_t'{base + 8'd7, p2[7:0], fin, 1'b0});
    endfunction

    // Feedback divider from a VCO frequency over the crystal.
    function automatic void predict_feedback(input bit [63:0] f, input bit fin);
        bit [63:0] x;
        bit [63:0] a;
        bit [63:0] b;
        x = 64'(xtal_hz);
        a = f / x;
        b = ((f % x) * 64'(fdwe_pkg::FRAC_DENOM)) / x;
        pll_hz = f[fdwe_pkg::PLL_W-1:0];
        encode_divider(fdwe_pkg::BASE_FEEDBACK, a, b, 64'(fdwe_pkg::FRAC_DENOM), fin);
    endfunction

    // Output divider from the stored VCO frequency over f (both times 1000).
    function automatic void predict_output(input bit [63:0] f);
        bit [63:0] n;
        bit [63:0] a;
        bit [63:0] b;
        n = 64'(pll_hz) * 64'(fdwe_pkg::MULT_K);
        a = n / f;
        b = ((n % f) * 64'(fdwe_pkg::FRAC_DENOM)) / f;
        encode_divider(fdwe_pkg::BASE_OUTPUT, a, b, 64'(fdwe_pkg::FRAC_DENOM), 1'b1);
    endfunction

    // Expected byte writes of one accepted command.
    function automatic void predict_command(input divider_cmd_t it);
        bit [63:0] f;
        f = 64'(it.freq_value);
        case (it.cmd)
            fdwe_pkg::CMD_FB_FREQ:
                if (xtal_hz == '0)
                    pending_writes.push_back(ERROR_WRITE);
                else
                    predict_feedback(f, 1'b1);
            fdwe_pkg::CMD_OUT_FREQ:
                if (f == 0)
                    pending_writes.push_back(ERROR_WRITE);
                else
                    predict_output(f);
            fdwe_pkg::CMD_FB_ABC, fdwe_pkg::CMD_OUT_ABC:
                if (it.frac_den == '0)
                    pending_writes.push_back(ERROR_WRITE);
                else
                    encode_divider((it.cmd == fdwe_pkg::CMD_FB_ABC) ?
                                   fdwe_pkg::BASE_FEEDBACK : fdwe_pkg::BASE_OUTPUT,
                                   64'(it.int_part), 64'(it.frac_num),
                                   64'(it.frac_den), 1'b1);
            fdwe_pkg::CMD_COMBINED:
                if (xtal_hz == '0 || f == 0)
                    pending_writes.push_back(ERROR_WRITE);
                else
                begin
                    predict_feedback(64'(vco_hz), 1'b0);
                    predict_output(f);
                end
            default:
                ;
        endcase
    endfunction

    // Random command: mostly valid codes with realistic or full-range fields.
    function automatic divider_cmd_t random_command();
        divider_cmd_t it;
        bit [63:0]    wide;
        int           pick;
        wide = {$urandom, $urandom};
        it.freq_value  = wide[fdwe_pkg::FREQ_W-1:0];
        it.int_part    = fdwe_pkg::INT_W'($urandom);
        it.frac_num    = fdwe_pkg::FRAC_W'($urandom);
        it.frac_den    = fdwe_pkg::FRAC_W'($urandom);
        if ($urandom_range(0, 99) < 4)
            it.cmd = fdwe_pkg::CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
        else
            it.cmd = fdwe_pkg::CMD_W'($urandom_range(fdwe_pkg::CMD_FB_FREQ,
                                                     fdwe_pkg::CMD_COMBINED));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            it.freq_value = '0;
        else if (pick < 12)
            it.freq_value = fdwe_pkg::FREQ_W'($urandom_range(1, 4));
        else if (pick < 70)
        begin
            if (it.cmd == fdwe_pkg::CMD_FB_FREQ)
                it.freq_value = fdwe_pkg::FREQ_W'($urandom_range(600000000, 900000000));
            else
                it.freq_value = fdwe_pkg::FREQ_W'(64'($urandom_range(8000, 200000000))
                                * 64'(fdwe_pkg::MULT_K) + 64'($urandom_range(0, 999)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            it.frac_den = '0;
        else if (pick < 15)
            it.frac_den = fdwe_pkg::FRAC_W'($urandom_range(1, 16));
        else if (pick < 30)
            it.frac_den = fdwe_pkg::FRAC_DENOM;
        if ($urandom_range(0, 3) == 0)
            it.int_part = fdwe_pkg::INT_W'($urandom_range(8, 2048));
        return it;
    endfunction

    // Lower valid at the next falling edge so nothing is offered.
    task automatic hold_input();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every expected byte write has arrived.
    task automatic wait_for_writes();
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // Offer one command and record its expected writes once accepted.
    task automatic send_command(input divider_cmd_t it, input bit typed_error);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.cmd        <= it.cmd;
        in_ch.freq_value <= it.freq_value;
        in_ch.int_part   <= it.int_part;
        in_ch.frac_num   <= it.frac_num;
        in_ch.frac_den   <= it.frac_den;
        in_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        if (typed_error)
            pending_writes.push_back(ERROR_WRITE);
        else
            predict_command(it);
    endtask

    // One APB transfer; a read returns the data seen in the access cycle.
    task automatic apb_transfer(input bit wr, input logic idx,
                                input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both registers while idle, read them back, update the predictor.
    task automatic program_registers(input logic [fdwe_pkg::XTAL_W-1:0] xtal,
                                     input logic [fdwe_pkg::VCO_W-1:0] vco);
        logic [31:0] rd;
        apb_transfer(1'b1, fdwe_pkg::REG_XTAL, 32'(xtal), rd);
        apb_transfer(1'b1, fdwe_pkg::REG_VCO, 32'(vco), rd);
        apb_transfer(1'b0, fdwe_pkg::REG_XTAL, 32'd0, rd);
        if (rd[fdwe_pkg::XTAL_W-1:0] !== xtal)
            flag_mismatch($sformatf("crystal register read %0d, wrote %0d",
                                    rd[fdwe_pkg::XTAL_W-1:0], xtal));
        apb_transfer(1'b0, fdwe_pkg::REG_VCO, 32'd0, rd);
        if (rd[fdwe_pkg::VCO_W-1:0] !== vco)
            flag_mismatch($sformatf("VCO register read %0d, wrote %0d",
                                    rd[fdwe_pkg::VCO_W-1:0], vco));
        xtal_hz = xtal;
        vco_hz  = vco;
    endtask

    // Result side stalls at random except during the calm stretch.
    always @(negedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each accepted byte write with the oldest expectation.
    always @(posedge clk)
    begin
        reg_write_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_writes.size() == 0)
                flag_mismatch($sformatf("unexpected write addr %0d byte %02h",
                                        out_ch.reg_addr, out_ch.reg_byte));
            else
            begin
                want = pending_writes.pop_front();
                if (out_ch.reg_addr !== want.reg_addr)
                    flag_mismatch($sformatf("reg_addr %0d, want %0d",
                                            out_ch.reg_addr, want.reg_addr));
                if (out_ch.reg_byte !== want.reg_byte)
                    flag_mismatch($sformatf("reg_byte %02h at addr %0d, want %02h",
                                            out_ch.reg_byte, want.reg_addr,
                                            want.reg_byte));
                if (out_ch.last_write !== want.last_write)
                    flag_mismatch($sformatf("last_write %b at addr %0d, want %b",
                                            out_ch.last_write, want.reg_addr,
                                            want.last_write));
                if (out_ch.div_error !== want.div_error)
                    flag_mismatch($sformatf("div_error %b at addr %0d, want %b",
                                            out_ch.div_error, want.reg_addr,
                                            want.div_error));
            end
        end
    end

    // Main sequence
    initial
    begin
        phase_t       phases [NUM_PHASES];
        divider_cmd_t it;
        int           sent;

        rst_n            = 1'b0;
        calm             = 1'b0;
        mismatch_count   = 0;
        cycle_count      = 0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = fdwe_pkg::CMD_FB_FREQ;
        in_ch.freq_value = '0;
        in_ch.int_part   = '0;
        in_ch.frac_num   = '0;
        in_ch.frac_den   = '0;
        out_ch.ready     = 1'b0;
        xtal_hz          = fdwe_pkg::XTAL_RESET;
        vco_hz           = fdwe_pkg::VCO_RESET;
        pll_hz           = '0;

        phases[0] = '{27'd1, 30'd1, 1'b0, 50};
        phases[1] = '{27'd100000000, 30'd1000000000, 1'b1, 50};
        phases[2] = '{{fdwe_pkg::XTAL_W{1'b1}}, {fdwe_pkg::VCO_W{1'b1}}, 1'b0, 50};
        phases[3] = '{27'd0, fdwe_pkg::VCO_W'($urandom_range(600000000, 900000000)),
                      1'b0, 25};
        phases[4] = '{fdwe_pkg::XTAL_W'($urandom_range(10000000, 50000000)),
                      fdwe_pkg::VCO_W'($urandom_range(600000000, 900000000)), 1'b0, 80};
        phases[5] = '{fdwe_pkg::XTAL_W'($urandom_range(1, 27'h7FFFFFF)),
                      fdwe_pkg::VCO_W'($urandom_range(1, 30'h3FFFFFFF)), 1'b0, 70};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset register values
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_command(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed_error);

        // Random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            hold_input();
            wait_for_writes();
            repeat (SETTLE_CYCLES) @(posedge clk);
            program_registers(phases[p].xtal, phases[p].vco);
            calm = phases[p].calm;
            sent = 0;
            while (sent < phases[p].count)
            begin
                it = random_command();
                send_command(it, 1'b0);
                if (it.cmd <= fdwe_pkg::CMD_COMBINED)
                    sent++;
                // Occasionally let the unit drain completely before going on.
                if ($urandom_range(0, 24) == 0)
                begin
                    hold_input();
                    wait_for_writes();
                end
            end
        end

        // Drain and let any late stray write show up
        hold_input();
        calm = 1'b0;
        wait_for_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("fractional_divider_word_encoder_unit test passed");
        else
            $display("fractional_divider_word_encoder_unit test failed");
        $finish;
    end

endmodule
